[rtl/core/pcrc_pkg.sv]
// shared types, constants and helper functions of the pcm rate/channel/depth converter
package pcrc_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int MAX_RUN_DEFAULT  = 16;
    localparam int RESULT_CAP       = 16;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUO_W            = 24;
    localparam int DIV_NUM_W        = 63;
    localparam int DIV_DEN_W        = 38;
    localparam int NOP_W            = 22;

    localparam logic [NOP_W-1:0] ONE_Q = NOP_W'(1) << FRAC_BITS;
    localparam logic [20:0]      UNITY_RATE = 21'(1) << FRAC_BITS;

    // depth codes
    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RATE      = 3'd0;
    localparam logic [2:0] REG_IN_CH     = 3'd1;
    localparam logic [2:0] REG_OUT_CH    = 3'd2;
    localparam logic [2:0] REG_IN_DEPTH  = 3'd3;
    localparam logic [2:0] REG_OUT_DEPTH = 3'd4;

    typedef struct packed {
        logic [20:0] rate;
        logic [1:0]  in_ch;
        logic [1:0]  out_ch;
        logic [1:0]  in_depth;
        logic [1:0]  out_depth;
    } t_cfg;

    typedef struct packed {
        logic [23:0] raw_a;
        logic [23:0] raw_b;
        logic [24:0] m0;
        logic [24:0] m1;
        logic        fin;
    } t_cmd;

    typedef struct packed {
        logic [24:0] m0;
        logic [24:0] m1;
    } t_map;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [4:0] depth_bits(input logic [1:0] code);
        logic [4:0] bits;
        unique case (code)
            DEPTH_8:  bits = 5'd8;
            DEPTH_16: bits = 5'd16;
            default:  bits = 5'd24;
        endcase
        return bits;
    endfunction

    function automatic logic [23:0] depth_mask(input logic [1:0] code);
        logic [23:0] m;
        unique case (code)
            DEPTH_8:  m = 24'h0000ff;
            DEPTH_16: m = 24'h00ffff;
            default:  m = 24'hffffff;
        endcase
        return m;
    endfunction

    // stereo to mono keeps the plain sum, the halving goes into the output scaling
    function automatic t_map map_frame(input logic [23:0] a, input logic [23:0] b,
                                       input logic ist, input logic ost);
        t_map mp;
        if (ist == ost) begin
            mp.m0 = {1'b0, a};
            mp.m1 = ist ? {1'b0, b} : 25'd0;
        end else if (ost) begin
            mp.m0 = {1'b0, a};
            mp.m1 = {1'b0, a};
        end else begin
            mp.m0 = {1'b0, a} + {1'b0, b};
            mp.m1 = 25'd0;
        end
        return mp;
    endfunction

    function automatic logic [23:0] scale_out(input logic [44:0] x, input logic [5:0] sh);
        logic [44:0] t;
        t = x >> sh;
        return t[23:0];
    endfunction

endpackage

[rtl/core/pcrc_front.sv]
// front end: takes input transfers, masks to input depth and maps channels
module pcrc_front (
    input  pcrc_pkg::t_cfg i_cfg,
    input  logic           i_tvalid,
    output logic           o_tready,
    input  logic [47:0]    i_tdata,   // first_sample [23:0], second_sample [47:24]
    input  logic           i_tlast,   // final_frame
    input  logic           i_q_full,
    output logic           o_push,
    output pcrc_pkg::t_cmd o_push_data
);
    import pcrc_pkg::*;

    logic [23:0] w_mask;
    logic [23:0] w_a;
    logic [23:0] w_b;
    t_map        w_map;

    assign w_mask = depth_mask(i_cfg.in_depth);
    assign w_a    = i_tdata[23:0] & w_mask;
    assign w_b    = i_tdata[47:24] & w_mask;
    assign w_map  = map_frame(w_a, w_b, i_cfg.in_ch[1], i_cfg.out_ch[1]);

    assign o_tready          = ~i_q_full;
    assign o_push            = i_tvalid & ~i_q_full;
    assign o_push_data.raw_a = w_a;
    assign o_push_data.raw_b = w_b;
    assign o_push_data.m0    = w_map.m0;
    assign o_push_data.m1    = w_map.m1;
    assign o_push_data.fin   = i_tlast;

endmodule

[rtl/core/pcrc_queue.sv]
// short command queue between front and back
module pcrc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcrc_pkg::t_cmd      i_push_data,
    input  logic                i_pop,
    output pcrc_pkg::t_cmd      o_pop_data,
    output pcrc_pkg::t_q_status o_status
);
    import pcrc_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[rtl/core/pcrc_divider.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit 24 bits
module pcrc_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pcrc_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [pcrc_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pcrc_pkg::QUO_W-1:0]    o_quo
);
    import pcrc_pkg::*;

    localparam int DSW = DIV_DEN_W + QUO_W - 1;
    localparam int CNW = $clog2(QUO_W);

    logic [DIV_NUM_W-1:0] r_rem;
    logic [DSW-1:0]       r_den;
    logic [QUO_W-1:0]     r_quo;
    logic [CNW-1:0]       r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_NUM_W-1:0] w_den_ext;
    logic                 w_ge;

    assign w_den_ext = DIV_NUM_W'(r_den);
    assign w_ge      = (r_rem >= w_den_ext);
    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_quo     = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= {i_den, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
            r_cnt <= CNW'(QUO_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_den_ext;
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_den <= r_den >> 1;
            r_cnt <= r_cnt - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

[rtl/core/pcrc_back.sv]
// back end: rate conversion sequencer, stream state and output register
module pcrc_back #(
    parameter int MAX_UPSAMPLE_RUN = pcrc_pkg::MAX_RUN_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcrc_pkg::t_cfg                 i_cfg,
    input  logic                           i_cfg_clr,
    input  logic                           i_q_valid,
    input  pcrc_pkg::t_cmd                 i_q_data,
    output logic                           o_q_pop,
    output logic                           o_div_start,
    output logic [pcrc_pkg::DIV_NUM_W-1:0] o_div_num,
    output logic [pcrc_pkg::DIV_DEN_W-1:0] o_div_den,
    input  logic                           i_div_done,
    input  logic [pcrc_pkg::QUO_W-1:0]     i_div_quo,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [47:0]                    o_tdata,   // left_out [23:0], right_out [47:24]
    output logic                           o_tlast    // last_of_run
);
    import pcrc_pkg::*;

    localparam int LIM = (MAX_UPSAMPLE_RUN < RESULT_CAP) ? MAX_UPSAMPLE_RUN : RESULT_CAP;
    localparam int NW  = $clog2(RESULT_CAP + 1);
    localparam logic [NW-1:0] LIM_N = NW'(LIM);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PASS    = 4'd1;
    localparam logic [3:0] ST_DN_OPEN = 4'd2;
    localparam logic [3:0] ST_DN_ACC0 = 4'd3;
    localparam logic [3:0] ST_DN_ACC1 = 4'd4;
    localparam logic [3:0] ST_DN_DIV0 = 4'd5;
    localparam logic [3:0] ST_DN_DIV1 = 4'd6;
    localparam logic [3:0] ST_UP_TOP  = 4'd7;
    localparam logic [3:0] ST_UP_SKIP = 4'd8;
    localparam logic [3:0] ST_UP_SKAD = 4'd9;
    localparam logic [3:0] ST_UP_ACC0 = 4'd10;
    localparam logic [3:0] ST_UP_ACC1 = 4'd11;
    localparam logic [3:0] ST_EMIT    = 4'd12;
    localparam logic [3:0] ST_END     = 4'd13;

    logic [3:0]       r_state;
    logic [3:0]       r_ret;
    t_cmd             r_cmd;
    logic [NW-1:0]    r_n;
    logic             r_run;
    logic             r_div_go;
    logic [46:0]      r_sum_l;
    logic [46:0]      r_sum_r;
    logic [46:0]      r_tot_l;
    logic [46:0]      r_tot_r;
    logic [NOP_W-1:0] r_nop;
    logic [23:0]      r_prior_l;
    logic [23:0]      r_prior_r;
    logic             r_have_prior;
    logic signed [43:0] r_prod;
    logic [23:0]      r_res_l;
    logic [23:0]      r_res_r;
    logic             r_pend_valid;
    logic [23:0]      r_pend_l;
    logic [23:0]      r_pend_r;
    logic             r_out_valid;
    logic [23:0]      r_out_l;
    logic [23:0]      r_out_r;
    logic             r_out_last;

    logic [4:0]       w_ib;
    logic [4:0]       w_ob;
    logic             w_dl;
    logic [5:0]       w_sh;
    logic [4:0]       w_up_s;
    logic [4:0]       w_dn_s;
    logic             w_mode_dn;
    logic             w_mode_up;
    logic [NOP_W-1:0] w_rate;
    logic [NOP_W-1:0] w_nop_eff;
    logic [NOP_W-1:0] w_avail;
    logic [NOP_W-1:0] w_skip_num;
    logic [21:0]      w_rden;
    t_map             w_pm;
    logic [24:0]      w_a0;
    logic [24:0]      w_a1;
    logic [25:0]      w_diff0;
    logic [25:0]      w_diff1;
    logic [17:0]      w_d;
    logic signed [17:0] w_mul_a;
    logic signed [25:0] w_mul_b;
    logic [44:0]      w_x0;
    logic [44:0]      w_x1;
    logic [44:0]      w_p0;
    logic [44:0]      w_p1;
    logic [46:0]      w_prod_u;
    logic [23:0]      w_omask;
    logic [23:0]      w_el;
    logic [23:0]      w_er;
    logic             w_out_free;
    logic             w_out_load;

    assign w_ib      = depth_bits(i_cfg.in_depth);
    assign w_ob      = depth_bits(i_cfg.out_depth);
    assign w_dl      = i_cfg.in_ch[1] & ~i_cfg.out_ch[1];
    assign w_sh      = 6'd16 + {5'd0, w_dl} + {1'b0, w_ib} - {1'b0, w_ob};
    assign w_up_s    = (w_ob > w_ib) ? (w_ob - w_ib) : 5'd0;
    assign w_dn_s    = (w_ib > w_ob) ? (w_ib - w_ob) : 5'd0;
    assign w_mode_dn = (i_cfg.rate > UNITY_RATE);
    assign w_mode_up = (i_cfg.rate < UNITY_RATE);
    assign w_rate    = {1'b0, i_cfg.rate};
    assign w_nop_eff = (r_nop == '0) ? w_rate : r_nop;
    assign w_avail   = ONE_Q - r_nop;
    assign w_skip_num = ONE_Q - r_nop + w_rate - NOP_W'(1);
    assign w_rden    = w_dl ? {i_cfg.rate, 1'b0} : {1'b0, i_cfg.rate};

    // left end of the interpolation interval: prior frame, or the final frame held
    assign w_pm    = map_frame(r_prior_l, r_prior_r, i_cfg.in_ch[1], i_cfg.out_ch[1]);
    assign w_a0    = r_run ? r_cmd.m0 : w_pm.m0;
    assign w_a1    = r_run ? r_cmd.m1 : w_pm.m1;
    assign w_diff0 = {1'b0, r_cmd.m0} - {1'b0, w_a0};
    assign w_diff1 = {1'b0, r_cmd.m1} - {1'b0, w_a1};
    assign w_d     = {2'b0, r_nop[15:0]};

    // a*(1-d) + b*d as a*1.0 + (b-a)*d
    assign w_x0 = {4'd0, w_a0, 16'd0} + {r_prod[43], r_prod};
    assign w_x1 = {4'd0, w_a1, 16'd0} + {r_prod[43], r_prod};
    assign w_p0 = {4'd0, r_cmd.m0, 16'd0};
    assign w_p1 = {4'd0, r_cmd.m1, 16'd0};
    assign w_prod_u = {3'd0, r_prod};

    assign w_omask    = depth_mask(i_cfg.out_depth);
    assign w_el       = r_res_l & w_omask;
    assign w_er       = i_cfg.out_ch[1] ? (r_res_r & w_omask) : 24'd0;
    assign w_out_free = ~r_out_valid | i_tready;
    // pending result moves into the output register
    assign w_out_load = r_pend_valid & w_out_free
                      & ((r_state == ST_EMIT) | (r_state == ST_END));

    assign o_q_pop  = (r_state == ST_IDLE) & i_q_valid;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_r, r_out_l};
    assign o_tlast  = r_out_last;

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            ST_DN_OPEN: begin
                w_mul_a = w_nop_eff[17:0];
                w_mul_b = {1'b0, r_cmd.m0};
            end
            ST_DN_ACC0: begin
                w_mul_a = r_nop[17:0];
                w_mul_b = {1'b0, r_cmd.m1};
            end
            ST_UP_TOP: begin
                w_mul_a = w_d;
                w_mul_b = w_diff0;
            end
            ST_UP_ACC0: begin
                w_mul_a = w_d;
                w_mul_b = w_diff1;
            end
            ST_UP_SKIP: begin
                w_mul_a = i_div_quo[17:0];
                w_mul_b = {5'd0, i_cfg.rate};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        o_div_start = 1'b0;
        o_div_num   = '0;
        o_div_den   = '0;
        unique case (r_state)
            ST_DN_DIV0: begin
                o_div_start = ~r_div_go;
                o_div_num   = {16'd0, r_tot_l} << w_up_s;
                o_div_den   = {16'd0, w_rden} << w_dn_s;
            end
            ST_DN_DIV1: begin
                o_div_start = ~r_div_go;
                o_div_num   = {16'd0, r_tot_r} << w_up_s;
                o_div_den   = {16'd0, w_rden} << w_dn_s;
            end
            ST_UP_SKIP: begin
                o_div_start = ~r_div_go;
                o_div_num   = {41'd0, w_skip_num};
                o_div_den   = {16'd0, w_rate};
            end
            default: begin
                o_div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        unique case (r_state)
            ST_PASS: begin
                r_res_l <= scale_out(w_p0, w_sh);
                r_res_r <= scale_out(w_p1, w_sh);
            end
            ST_DN_ACC0: begin
                r_tot_l <= r_sum_l + w_prod_u;
            end
            ST_DN_ACC1: begin
                r_tot_r <= r_sum_r + w_prod_u;
            end
            ST_DN_DIV0: begin
                if (r_div_go && i_div_done) begin
                    r_res_l <= i_div_quo;
                end
            end
            ST_DN_DIV1: begin
                if (r_div_go && i_div_done) begin
                    r_res_r <= i_div_quo;
                end
            end
            ST_UP_ACC0: begin
                r_res_l <= scale_out(w_x0, w_sh);
            end
            ST_UP_ACC1: begin
                r_res_r <= scale_out(w_x1, w_sh);
            end
            ST_EMIT: begin
                if (!r_pend_valid || w_out_free) begin
                    r_pend_l <= w_el;
                    r_pend_r <= w_er;
                end
                if (r_pend_valid && w_out_free) begin
                    r_out_l    <= r_pend_l;
                    r_out_r    <= r_pend_r;
                    r_out_last <= 1'b0;
                end
            end
            ST_END: begin
                if (r_pend_valid && w_out_free) begin
                    r_out_l    <= r_pend_l;
                    r_out_r    <= r_pend_r;
                    r_out_last <= 1'b1;
                end
            end
            default: begin
                r_res_l <= r_res_l;
            end
        endcase
    end

    // control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_END;
            r_n          <= '0;
            r_run        <= 1'b0;
            r_div_go     <= 1'b0;
            r_sum_l      <= '0;
            r_sum_r      <= '0;
            r_nop        <= '0;
            r_prior_l    <= '0;
            r_prior_r    <= '0;
            r_have_prior <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= w_out_load | (r_out_valid & ~i_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_n <= '0;
                        if (w_mode_dn) begin
                            r_state <= ST_DN_OPEN;
                        end else if (w_mode_up) begin
                            if (r_have_prior) begin
                                r_run   <= 1'b0;
                                r_state <= ST_UP_TOP;
                            end else if (i_q_data.fin) begin
                                r_run   <= 1'b1;
                                r_state <= ST_UP_TOP;
                            end else begin
                                r_state <= ST_END;
                            end
                        end else begin
                            r_state <= ST_PASS;
                        end
                    end
                end
                ST_PASS: begin
                    r_ret   <= ST_END;
                    r_state <= ST_EMIT;
                end
                ST_DN_OPEN: begin
                    if (w_nop_eff > ONE_Q) begin
                        // box stays open past this frame
                        r_sum_l <= r_sum_l + {6'd0, r_cmd.m0, 16'd0};
                        r_sum_r <= r_sum_r + {6'd0, r_cmd.m1, 16'd0};
                        r_nop   <= w_nop_eff - ONE_Q;
                        r_state <= ST_END;
                    end else begin
                        r_nop   <= w_nop_eff;
                        r_state <= ST_DN_ACC0;
                    end
                end
                ST_DN_ACC0: begin
                    r_sum_l <= {6'd0, r_cmd.m0, 16'd0} - w_prod_u;
                    r_state <= ST_DN_ACC1;
                end
                ST_DN_ACC1: begin
                    // rest of the frame opens the next box
                    r_sum_r <= {6'd0, r_cmd.m1, 16'd0} - w_prod_u;
                    r_nop   <= (w_avail != '0) ? (w_rate - w_avail) : '0;
                    r_state <= ST_DN_DIV0;
                end
                ST_DN_DIV0: begin
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (i_div_done) begin
                        r_div_go <= 1'b0;
                        r_state  <= ST_DN_DIV1;
                    end
                end
                ST_DN_DIV1: begin
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (i_div_done) begin
                        r_div_go <= 1'b0;
                        r_n      <= r_n + NW'(1);
                        r_ret    <= ST_END;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_UP_TOP: begin
                    if (r_nop >= ONE_Q) begin
                        r_nop <= r_nop - ONE_Q;
                        if (!r_run && r_cmd.fin) begin
                            r_run <= 1'b1;
                        end else begin
                            r_state <= ST_END;
                        end
                    end else if (r_n >= LIM_N) begin
                        if (i_cfg.rate == '0) begin
                            r_nop <= ONE_Q;
                        end else begin
                            r_state <= ST_UP_SKIP;
                        end
                    end else begin
                        r_state <= ST_UP_ACC0;
                    end
                end
                ST_UP_SKIP: begin
                    // positions beyond the run cap are used up without output
                    if (!r_div_go) begin
                        r_div_go <= 1'b1;
                    end else if (i_div_done) begin
                        r_div_go <= 1'b0;
                        r_state  <= ST_UP_SKAD;
                    end
                end
                ST_UP_SKAD: begin
                    r_nop   <= r_nop + r_prod[NOP_W-1:0];
                    r_state <= ST_UP_TOP;
                end
                ST_UP_ACC0: begin
                    r_state <= ST_UP_ACC1;
                end
                ST_UP_ACC1: begin
                    r_nop   <= r_nop + w_rate;
                    r_n     <= r_n + NW'(1);
                    r_ret   <= ST_UP_TOP;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_pend_valid) begin
                        r_pend_valid <= 1'b1;
                        r_state      <= r_ret;
                    end else if (w_out_free) begin
                        r_state <= r_ret;
                    end
                end
                ST_END: begin
                    if (!r_pend_valid || w_out_free) begin
                        if (r_pend_valid) begin
                            r_pend_valid <= 1'b0;
                        end
                        if (r_cmd.fin) begin
                            r_sum_l      <= '0;
                            r_sum_r      <= '0;
                            r_nop        <= '0;
                            r_prior_l    <= '0;
                            r_prior_r    <= '0;
                            r_have_prior <= 1'b0;
                        end else if (w_mode_up) begin
                            r_prior_l    <= r_cmd.raw_a;
                            r_prior_r    <= r_cmd.raw_b;
                            r_have_prior <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_cfg_clr) begin
                r_sum_l      <= '0;
                r_sum_r      <= '0;
                r_nop        <= '0;
                r_prior_l    <= '0;
                r_prior_r    <= '0;
                r_have_prior <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/pcm_rate_channel_depth_converter_core.sv]
// top level of the pcm rate, channel and depth converter
//
// usage
//   s_axis carries one input frame per transfer: tdata holds first_sample and
//   second_sample, tlast marks the final frame of a stream. m_axis carries the
//   output frames: tdata holds left_out and right_out, tlast marks the last
//   output caused by one input frame. an input frame gives zero to sixteen
//   outputs. the apb port holds rate ratio, channel counts and depth codes;
//   any valid write restarts the stream state and is done while the block
//   idles; the user keeps to this, the block itself does not enforce it.
// sequencing
//   downsampling divides the left and right box sums by the ratio, one after
//   the other, in the serial divider. upsampling computes each output through
//   the one shared multiplier; when the run cap is reached the skipped
//   positions go through the divider as well. a two-entry command queue lets
//   the front take frames while the back works.
// reset and stall
//   synchronous reset loads the register defaults (unity ratio, mono, 16 bit)
//   and clears the stream state. when m_axis stalls, the back holds one
//   result in the output register and one pending, then waits; the queue
//   fills and s_axis_tready drops.
module pcm_rate_channel_depth_converter_core #(
    parameter int MAX_UPSAMPLE_RUN = pcrc_pkg::MAX_RUN_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // first_sample [23:0], second_sample [47:24]
    input  logic        s_axis_tlast,   // final_frame
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // left_out [23:0], right_out [47:24]
    output logic        m_axis_tlast,   // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pcrc_pkg::*;

    // configuration registers
    logic [20:0] r_rate;
    logic [1:0]  r_in_ch;
    logic [1:0]  r_out_ch;
    logic [1:0]  r_in_depth;
    logic [1:0]  r_out_depth;

    logic [2:0]           w_idx;
    logic                 w_wr;
    logic                 w_cfg_clr;
    t_cfg                 w_cfg;
    logic                 w_push;
    t_cmd                 w_push_data;
    logic                 w_pop;
    t_cmd                 w_pop_data;
    t_q_status            w_q_status;
    logic                 w_div_start;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [QUO_W-1:0]     w_div_quo;

    assign pready    = 1'b1;
    assign w_idx     = paddr[4:2];
    assign w_wr      = psel & penable & pwrite;
    // writes beyond the register list leave the stream alone
    assign w_cfg_clr = w_wr & (w_idx <= REG_OUT_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= UNITY_RATE;
            r_in_ch     <= 2'd1;
            r_out_ch    <= 2'd1;
            r_in_depth  <= DEPTH_16;
            r_out_depth <= DEPTH_16;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RATE:      r_rate      <= pwdata[20:0];
                REG_IN_CH:     r_in_ch     <= pwdata[1:0];
                REG_OUT_CH:    r_out_ch    <= pwdata[1:0];
                REG_IN_DEPTH:  r_in_depth  <= pwdata[1:0];
                REG_OUT_DEPTH: r_out_depth <= pwdata[1:0];
                default:       r_rate      <= r_rate;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RATE:      prdata = {11'd0, r_rate};
            REG_IN_CH:     prdata = {30'd0, r_in_ch};
            REG_OUT_CH:    prdata = {30'd0, r_out_ch};
            REG_IN_DEPTH:  prdata = {30'd0, r_in_depth};
            REG_OUT_DEPTH: prdata = {30'd0, r_out_depth};
            default:       prdata = 32'd0;
        endcase
    end

    assign w_cfg.rate      = r_rate;
    assign w_cfg.in_ch     = r_in_ch;
    assign w_cfg.out_ch    = r_out_ch;
    assign w_cfg.in_depth  = r_in_depth;
    assign w_cfg.out_depth = r_out_depth;

    pcrc_front u_front (
        .i_cfg       (w_cfg),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tlast     (s_axis_tlast),
        .i_q_full    (w_q_status.full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    pcrc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    pcrc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    pcrc_back #(
        .MAX_UPSAMPLE_RUN (MAX_UPSAMPLE_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cfg_clr   (w_cfg_clr),
        .i_q_valid   (~w_q_status.empty),
        .i_q_data    (w_pop_data),
        .o_q_pop     (w_pop),
        .o_div_start (w_div_start),
        .o_div_num   (w_div_num),
        .o_div_den   (w_div_den),
        .i_div_done  (w_div_done),
        .i_div_quo   (w_div_quo),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

    // back never restarts the divider while a division runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // back only takes commands that the queue holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty command queue");

    // no result is presented right after reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // a full queue holds off the input stream
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_q_status.full) && !$past(w_pop) |-> !w_push)
        else $error("push into full command queue");

endmodule

[tb/pcm_rate_channel_depth_converter_checker.sv]
// checker for the pcm rate/channel/depth converter: predicts output frames and compares them
module pcm_rate_channel_depth_converter_checker
    import pcrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_frames_out
);

    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
    localparam int RUN_LIMIT = (MAX_RUN_DEFAULT < RESULT_CAP) ? MAX_RUN_DEFAULT : RESULT_CAP;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic        last;
    } t_out_frame;

    t_out_frame out_frames_due[$];

    // configuration copy
    logic [20:0] rate;
    logic [1:0]  in_ch, out_ch, in_depth, out_depth;

    // stream state
    logic [63:0] acc_left, acc_right, box_left, up_pos;
    logic [23:0] prev_left, prev_right;
    logic        prev_valid;
    int          fails, outs;

    assign o_pending    = out_frames_due.size();
    assign o_fail_count = fails;
    assign o_frames_out = outs;

    function automatic int sample_bits(logic [1:0] code);
        return code == DEPTH_8 ? 8 : (code == DEPTH_16 ? 16 : 24);
    endfunction

    function automatic logic [63:0] floor_scale(logic [63:0] num, logic [63:0] den, int s);
        logic [63:0] q, r;
        if (s >= 0) begin
            q = num / den;
            r = num % den;
            return (q << s) + ((r << s) / den);
        end
        return num / (den << (-s));
    endfunction

    function automatic void restart_stream();
        acc_left   = 0;
        acc_right  = 0;
        box_left   = 0;
        up_pos     = 0;
        prev_left  = 0;
        prev_right = 0;
        prev_valid = 1'b0;
    endfunction

    // channel map, returns the divisor
    function automatic logic [63:0] map_channels(logic [63:0] a, logic [63:0] b,
                                                 output logic [63:0] c0,
                                                 output logic [63:0] c1);
        logic ist, ost;
        ist = in_ch >= 2;
        ost = out_ch >= 2;
        if (ist == ost) begin
            c0 = a;
            c1 = ist ? b : 0;
            return 1;
        end
        if (ost) begin
            c0 = a;
            c1 = a;
            return 1;
        end
        c0 = a + b;
        c1 = 0;
        return 2;
    endfunction

    function automatic void queue_frame(logic [63:0] v0, logic [63:0] v1);
        t_out_frame f;
        logic [63:0] m;
        m = (64'd1 << sample_bits(out_depth)) - 1;
        f.left  = 24'(v0 & m);
        f.right = (out_ch >= 2) ? 24'(v1 & m) : 24'd0;
        f.last  = 1'b0;
        out_frames_due.push_back(f);
    endfunction

    // interpolated outputs while the position stays inside the current interval
    function automatic int interpolate(int n, logic [63:0] r, logic [63:0] a0, logic [63:0] a1,
                                       logic [63:0] b0, logic [63:0] b1, logic [63:0] div,
                                       int s);
        logic [63:0] d, e;
        while (up_pos < ONE_F) begin
            if (n >= RUN_LIMIT) begin
                // skipped outputs still use up their positions
                if (r == 0)
                    up_pos = ONE_F;
                else
                    up_pos = up_pos + ((ONE_F - up_pos + r - 1) / r) * r;
                break;
            end
            d = up_pos;
            e = ONE_F - d;
            queue_frame(floor_scale(a0 * e + b0 * d, ONE_F * div, s),
                        floor_scale(a1 * e + b1 * d, ONE_F * div, s));
            n++;
            up_pos = up_pos + r;
        end
        up_pos = up_pos - ONE_F;
        return n;
    endfunction

    function automatic void predict_frame(logic [23:0] first, logic [23:0] second, logic fin);
        int          ib, s, n, start;
        logic [63:0] msk, a, b, r, c0, c1, p0, p1, div, avail, w;
        ib    = sample_bits(in_depth);
        s     = sample_bits(out_depth) - ib;
        msk   = (64'd1 << ib) - 1;
        a     = first & msk;
        b     = second & msk;
        r     = rate;
        div   = map_channels(a, b, c0, c1);
        n     = 0;
        start = out_frames_due.size();
        if (rate > UNITY_RATE) begin
            // box average over rate input frames
            avail = ONE_F;
            while (avail > 0) begin
                if (up_pos == 0) up_pos = r;
                w = (avail < up_pos) ? avail : up_pos;
                acc_left  = acc_left + w * c0;
                acc_right = acc_right + w * c1;
                avail     = avail - w;
                up_pos    = up_pos - w;
                box_left  = w;
                if (up_pos == 0 && n < RUN_LIMIT) begin
                    queue_frame(floor_scale(acc_left, r * div, s),
                                floor_scale(acc_right, r * div, s));
                    n++;
                    acc_left  = 0;
                    acc_right = 0;
                end
            end
        end else if (rate < UNITY_RATE) begin
            if (prev_valid) begin
                void'(map_channels(prev_left, prev_right, p0, p1));
                n = interpolate(n, r, p0, p1, c0, c1, div, s);
            end
            // final frame held past the end of the stream
            if (fin) n = interpolate(n, r, c0, c1, c0, c1, div, s);
            prev_left  = 24'(a);
            prev_right = 24'(b);
            prev_valid = 1'b1;
        end else begin
            queue_frame(floor_scale(c0, div, s), floor_scale(c1, div, s));
            n = 1;
        end
        if (fin) restart_stream();
        if (out_frames_due.size() > start)
            out_frames_due[out_frames_due.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_out_frame want;
        if (!i_rst_n) begin
            rate      = UNITY_RATE;
            in_ch     = 2'd1;
            out_ch    = 2'd1;
            in_depth  = DEPTH_16;
            out_depth = DEPTH_16;
            restart_stream();
            out_frames_due.delete();
            fails = 0;
            outs  = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                outs++;
                if (out_frames_due.size() == 0) begin
                    $error("output transfer with nothing expected: data %h last %b",
                           m_axis_tdata, m_axis_tlast);
                    fails++;
                end else begin
                    want = out_frames_due.pop_front();
                    if (m_axis_tdata[23:0] !== want.left) begin
                        $error("left_out expected %h got %h", want.left, m_axis_tdata[23:0]);
                        fails++;
                    end
                    if (m_axis_tdata[47:24] !== want.right) begin
                        $error("right_out expected %h got %h", want.right, m_axis_tdata[47:24]);
                        fails++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run expected %b got %b", want.last, m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_frame(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tlast);
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_RATE:      begin rate      = pwdata[20:0]; restart_stream(); end
                    REG_IN_CH:     begin in_ch     = pwdata[1:0];  restart_stream(); end
                    REG_OUT_CH:    begin out_ch    = pwdata[1:0];  restart_stream(); end
                    REG_IN_DEPTH:  begin in_depth  = pwdata[1:0];  restart_stream(); end
                    REG_OUT_DEPTH: begin out_depth = pwdata[1:0];  restart_stream(); end
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/pcm_rate_channel_depth_converter_core_test.sv]
// testbench top for the pcm rate/channel/depth converter: stimulus, idling and verdict
module pcm_rate_channel_depth_converter_core_test;
    import pcrc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [47:0] s_axis_tdata;  // first_sample [23:0], second_sample [47:24]
    logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [47:0] m_axis_tdata;  // left_out [23:0], right_out [47:24]
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    int pending, fail_count, frames_out;
    int gap_pct, stall_pct;
    int frames_in, settings_used;

    pcm_rate_channel_depth_converter_core i_dut (.*);

    pcm_rate_channel_depth_converter_checker i_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_fail_count(fail_count), .o_frames_out(frames_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // hard limit on run time
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // two-phase apb write: setup then access
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one input transfer, with a random idle gap before it
    task automatic send_frame(logic [23:0] first, logic [23:0] second, logic fin);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {second, first};
        s_axis_tlast  = fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        frames_in++;
    endtask

    // wait for the block to drain, with room for frames that give no output
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic load_setting(logic [20:0] rate, logic [1:0] ich, logic [1:0] och,
                                logic [1:0] idep, logic [1:0] odep);
        drain();
        reg_write(REG_RATE, 32'(rate));
        reg_write(REG_IN_CH, 32'(ich));
        reg_write(REG_OUT_CH, 32'(och));
        reg_write(REG_IN_DEPTH, 32'(idep));
        reg_write(REG_OUT_DEPTH, 32'(odep));
        settings_used++;
    endtask

    // random frame: mostly random content, sometimes full-scale or zero
    task automatic send_random(int pos);
        logic [23:0] a, b;
        logic        fin;
        case ($urandom_range(9))
            0:       begin a = 24'hffffff; b = 24'hffffff; end
            1:       begin a = 24'h000000; b = 24'hffffff; end
            default: begin a = 24'($urandom); b = 24'($urandom); end
        endcase
        // streams of a dozen frames or so, ended by the final flag
        fin = ($urandom_range(11) == 0) || (pos % 17 == 16);
        send_frame(a, b, fin);
    endtask

    logic [20:0] ratios [13];
    logic [1:0]  ich_set [13], och_set [13], idep_set [13], odep_set [13];

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        frames_in     = 0;
        settings_used = 1;

        // settings: pass-through, up and down, tiny and huge ratios, odd codes
        ratios = '{21'd65536, 21'd65536, 21'd65536, 21'd4096, 21'd32768, 21'd0, 21'd1,
                   21'd98304, 21'd1048576, 21'h1fffff, 21'd200000, 21'd50000, 21'd40000};
        ich_set  = '{2, 2, 1, 1, 2, 2, 1, 2, 2, 1, 3, 0, 2};
        och_set  = '{2, 1, 2, 2, 2, 1, 1, 1, 2, 2, 0, 3, 1};
        idep_set = '{DEPTH_24, DEPTH_8, DEPTH_24, DEPTH_16, DEPTH_8, 3, DEPTH_24, DEPTH_16,
                     DEPTH_24, DEPTH_8, DEPTH_16, 3, DEPTH_8};
        odep_set = '{DEPTH_24, DEPTH_24, DEPTH_8, DEPTH_24, DEPTH_8, DEPTH_16, DEPTH_8,
                     DEPTH_16, DEPTH_8, DEPTH_24, 3, DEPTH_24, DEPTH_16};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed frames under the reset setting: extremes and stream ends
        send_frame(24'h000000, 24'h000000, 1'b0);
        send_frame(24'hffffff, 24'hffffff, 1'b0);
        send_frame(24'hffffff, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'hffffff, 1'b1);
        send_frame(24'h123456, 24'habcdef, 1'b1);
        send_frame(24'h00ff00, 24'hff00ff, 1'b0);

        // a short upsampled stream with a held final frame and an over-cap tiny ratio
        load_setting(21'd16384, 2'd2, 2'd2, DEPTH_16, DEPTH_24);
        send_frame(24'h000000, 24'hffffff, 1'b0);
        send_frame(24'hffffff, 24'h000000, 1'b0);
        send_frame(24'h008000, 24'h008000, 1'b1);
        load_setting(21'd2048, 2'd1, 2'd1, DEPTH_24, DEPTH_8);
        send_frame(24'hffffff, 24'h000000, 1'b0);
        send_frame(24'h000000, 24'h000000, 1'b1);
        // downsampling with a fractional box, stereo folded to mono
        load_setting(21'd163840, 2'd2, 2'd1, DEPTH_24, DEPTH_16);
        repeat (6) send_frame(24'hffffff, 24'hffffff, 1'b0);
        send_frame(24'h7fffff, 24'h800000, 1'b1);

        // random phases, idling rotates through none, sender, receiver, both
        for (int ph = 0; ph < 13; ph++) begin
            load_setting(ph == 12 ? 21'($urandom_range(4096, 1048576)) : ratios[ph],
                         ich_set[ph], och_set[ph], idep_set[ph], odep_set[ph]);
            case (ph % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 58; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 27; stall_pct = 27; end
            endcase
            for (int k = 0; k < 34; k++) begin
                if (k == 12) begin
                    // hold off until the block has delivered everything
                    @(negedge i_clk);
                    s_axis_tvalid = 1'b0;
                    while (pending != 0) @(posedge i_clk);
                end
                send_random(k);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        stall_pct     = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d input frames and %0d output frames over %0d register settings",
                 frames_in, frames_out, settings_used);
        $display("including up, down and unity ratios, channel folding and all depth codes");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/pcrc_pkg.sv
rtl/core/pcrc_front.sv
rtl/core/pcrc_queue.sv
rtl/core/pcrc_divider.sv
rtl/core/pcrc_back.sv
rtl/core/pcm_rate_channel_depth_converter_core.sv
tb/pcm_rate_channel_depth_converter_checker.sv
tb/pcm_rate_channel_depth_converter_core_test.sv
